// File: hdl/tte_pkg.sv
// shared constants and types of the tap tempo estimator
package tte_pkg;

  localparam int WINDOW_DEPTH_DEF = 4;

  localparam int TIME_W     = 32;
  localparam int BPM_W      = 10;
  localparam int IVL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BPM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BPM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_TMO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVL  = 3'd4;

  // register reset values
  localparam logic [BPM_W-1:0] MIN_BPM_RST = 10'd30;
  localparam logic [BPM_W-1:0] MAX_BPM_RST = 10'd300;
  localparam logic [IVL_W-1:0] SEQ_TMO_RST = 16'd2000;
  localparam logic [IVL_W-1:0] MIN_IVL_RST = 16'd100;
  localparam logic [IVL_W-1:0] MAX_IVL_RST = 16'd2000;

  // window control from the sequencer
  typedef struct packed {
    logic             clear;
    logic             push;
    logic [IVL_W-1:0] data;
  } win_ctl_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/tte_if.sv
// tap and tempo channel interfaces
interface tte_tap_if;
  logic                        valid;
  logic                        ready;
  logic [tte_pkg::TIME_W-1:0]  tap_time_ms;

  modport source (output valid, output tap_time_ms, input ready);
  modport sink   (input valid, input tap_time_ms, output ready);
endinterface

interface tte_bpm_if;
  logic                       valid;
  logic                       ready;
  logic [tte_pkg::BPM_W-1:0]  bpm;

  modport source (output valid, output bpm, input ready);
  modport sink   (input valid, input bpm, output ready);
endinterface

// File: hdl/tte_window.sv
// sliding window of tap intervals with fill count
module tte_window #(
  parameter int WINDOW_DEPTH = tte_pkg::WINDOW_DEPTH_DEF,
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1),
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tte_pkg::win_ctl_t            ctl,
  input  logic [IDX_W-1:0]             rd_idx,
  output logic [tte_pkg::IVL_W-1:0]    rd_data,
  output logic [FILL_W-1:0]            fill
);

  logic [tte_pkg::IVL_W-1:0] win_r [WINDOW_DEPTH];
  logic [FILL_W-1:0]         fill_r;
  logic [FILL_W-1:0]         fill_nxt;

  // newest entry at index 0, oldest falls off the far end
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      win_r[0] <= ctl.data;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.clear) begin
      fill_nxt = '0;
    end else if (ctl.push && (fill_r != FILL_W'(WINDOW_DEPTH))) begin
      fill_nxt = FILL_W'(fill_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign rd_data = win_r[rd_idx];
  assign fill    = fill_r;

endmodule

// File: hdl/tte_div.sv
// restoring divider, one quotient bit per cycle
module tte_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 19
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     dividend,
  input  logic [DEN_W-1:0]     divisor,
  output tte_pkg::div_stat_t   stat,
  output logic [NUM_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= CNT_W'(cnt_r - 1'b1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// File: hdl/tap_tempo_estimator.sv
// tap tempo estimator top level: sequencer, registers and output stage
// One tap beat is taken at a time. A tap that ends early (bad limits, first tap or
// timeout, interval out of range) goes from the check state straight to the done state.
// A tap that enters the window is summed over fill entries, where fill is
// the window count after the tap, and NUM_W = 17 + clog2(WINDOW_DEPTH+1) is the number
// of steps of the shared restoring divider (20 steps at the default depth of 4).
// The divider produces one quotient bit per cycle; the window sum adds one
// entry per cycle through the single read port of the window. The result sits in an
// output register, so the next tap is taken while the previous tempo still waits,
// but a finished result only leaves the sequencer once that register is free.
// Configuration writes land at once; they are meant for idle times only.
module tap_tempo_estimator #(
  parameter int WINDOW_DEPTH = tte_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tte_tap_if.sink                         in_tap,
  tte_bpm_if.source                       out_bpm,
  input  logic                            cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tte_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = tte_pkg::IVL_W + FILL_W;
  localparam int NUM_W  = SUM_W + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SUM   = 6'b000100,
    S_PREP  = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [tte_pkg::BPM_W-1:0] min_bpm_r;
  logic [tte_pkg::BPM_W-1:0] max_bpm_r;
  logic [tte_pkg::IVL_W-1:0] seq_tmo_r;
  logic [tte_pkg::IVL_W-1:0] min_ivl_r;
  logic [tte_pkg::IVL_W-1:0] max_ivl_r;

  // tap history
  logic [tte_pkg::TIME_W-1:0] last_r, last_nxt;
  logic                       have_r, have_nxt;
  logic [tte_pkg::TIME_W-1:0] tap_r;

  // sum loop and result
  logic [FILL_W-1:0]          cnt_r, cnt_nxt;
  logic [SUM_W-1:0]           acc_r, acc_nxt;
  logic [tte_pkg::BPM_W-1:0]  res_r, res_nxt;

  // output register
  logic                       out_valid_r;
  logic [tte_pkg::BPM_W-1:0]  out_bpm_r;
  logic                       out_load;

  // window and divider hookup
  tte_pkg::win_ctl_t          win_ctl;
  logic [IDX_W-1:0]           win_rd_idx;
  logic [tte_pkg::IVL_W-1:0]  win_rd_data;
  logic [FILL_W-1:0]          win_fill;

  logic                       div_start;
  logic [NUM_W-1:0]           div_num;
  tte_pkg::div_stat_t         div_stat;
  logic [NUM_W-1:0]           div_quo;

  // tap checks
  logic [tte_pkg::TIME_W-1:0] gap;
  logic                       limits_bad;
  logic                       new_seq;
  logic                       ivl_bad;
  logic                       in_acc;

  assign in_acc     = in_tap.valid && in_tap.ready;
  assign gap        = tap_r - last_r;
  assign limits_bad = (min_bpm_r == '0) || (max_bpm_r == '0) || (min_bpm_r > max_bpm_r);
  assign new_seq    = !have_r || (gap > {16'd0, seq_tmo_r});
  assign ivl_bad    = (gap < {16'd0, min_ivl_r}) || (gap > {16'd0, max_ivl_r});

  // numerator 60000*count + sum/2 for rounding to nearest
  assign div_num = NUM_W'(NUM_W'(tte_pkg::MS_PER_MINUTE) * NUM_W'(win_fill))
                 + NUM_W'(acc_r >> 1);

  assign win_rd_idx = cnt_r[IDX_W-1:0];

  // config writes, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bpm_r <= tte_pkg::MIN_BPM_RST;
      max_bpm_r <= tte_pkg::MAX_BPM_RST;
      seq_tmo_r <= tte_pkg::SEQ_TMO_RST;
      min_ivl_r <= tte_pkg::MIN_IVL_RST;
      max_ivl_r <= tte_pkg::MAX_IVL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tte_pkg::CFG_MIN_BPM: min_bpm_r <= cfg_wdata[tte_pkg::BPM_W-1:0];
        tte_pkg::CFG_MAX_BPM: max_bpm_r <= cfg_wdata[tte_pkg::BPM_W-1:0];
        tte_pkg::CFG_SEQ_TMO: seq_tmo_r <= cfg_wdata;
        tte_pkg::CFG_MIN_IVL: min_ivl_r <= cfg_wdata;
        tte_pkg::CFG_MAX_IVL: max_ivl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    have_nxt      = have_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    win_ctl.clear = 1'b0;
    win_ctl.push  = 1'b0;
    win_ctl.data  = gap[tte_pkg::IVL_W-1:0];
    div_start     = 1'b0;
    out_load      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_nxt = '0;
        if (limits_bad) begin
          // nothing changes on bad limits
          state_nxt = S_DONE;
        end else if (new_seq) begin
          win_ctl.clear = 1'b1;
          last_nxt      = tap_r;
          have_nxt      = 1'b1;
          state_nxt     = S_DONE;
        end else if (ivl_bad) begin
          win_ctl.clear = 1'b1;
          last_nxt      = tap_r;
          state_nxt     = S_DONE;
        end else begin
          win_ctl.push = 1'b1;
          last_nxt     = tap_r;
          cnt_nxt      = '0;
          acc_nxt      = '0;
          state_nxt    = S_SUM;
        end
      end
      S_SUM: begin
        // one window entry per cycle, fill is at least one here
        acc_nxt = SUM_W'(acc_r + SUM_W'(win_rd_data));
        cnt_nxt = FILL_W'(cnt_r + 1'b1);
        if (FILL_W'(cnt_r + 1'b1) == win_fill) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (acc_r == '0) begin
          // all stored intervals are zero
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          priority if (div_quo < NUM_W'(min_bpm_r)) begin
            res_nxt = min_bpm_r;
          end else if (div_quo > NUM_W'(max_bpm_r)) begin
            res_nxt = max_bpm_r;
          end else begin
            res_nxt = div_quo[tte_pkg::BPM_W-1:0];
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_bpm.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      have_r  <= 1'b0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      have_r  <= have_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tap_r <= in_tap.tap_time_ms;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bpm.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bpm_r <= res_r;
    end
  end

  assign in_tap.ready  = (state_r == S_IDLE);
  assign out_bpm.valid = out_valid_r;
  assign out_bpm.bpm   = out_bpm_r;

  tte_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .rd_idx  (win_rd_idx),
    .rd_data (win_rd_data),
    .fill    (win_fill)
  );

  tte_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (acc_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

endmodule

// File: hdl/tte_checker.sv
// port-level checks of the tap tempo estimator and their binding
module tte_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tte_pkg::BPM_W-1:0]       out_bpm,
  input logic                            cfg_we,
  input logic [tte_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input logic [tte_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [tte_pkg::BPM_W-1:0] min_bpm_r;
  logic [tte_pkg::BPM_W-1:0] max_bpm_r;
  logic [1:0]                pend_r;
  logic                      in_acc;
  logic                      out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // shadow of the tempo limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bpm_r <= tte_pkg::MIN_BPM_RST;
      max_bpm_r <= tte_pkg::MAX_BPM_RST;
    end else if (cfg_we && (cfg_idx == tte_pkg::CFG_MIN_BPM)) begin
      min_bpm_r <= cfg_wdata[tte_pkg::BPM_W-1:0];
    end else if (cfg_we && (cfg_idx == tte_pkg::CFG_MAX_BPM)) begin
      max_bpm_r <= cfg_wdata[tte_pkg::BPM_W-1:0];
    end
  end

  // taps taken whose beat has not left yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= 2'(pend_r + {1'b0, in_acc} - {1'b0, out_acc});
    end
  end

  a_busy_after_tap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("tap accepted while previous tap still in work");

  a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result beat without a pending tap");

  a_bpm_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bpm == '0) || ((out_bpm >= min_bpm_r) && (out_bpm <= max_bpm_r)))
    else $error("tempo outside configured limits");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bpm))
    else $error("stalled result beat changed");

endmodule

bind tap_tempo_estimator tte_checker u_tte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_tap.valid),
  .in_ready  (in_tap.ready),
  .out_valid (out_bpm.valid),
  .out_ready (out_bpm.ready),
  .out_bpm   (out_bpm.bpm),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx),
  .cfg_wdata (cfg_wdata)
);
